[src/btc_pkg.sv]
`default_nettype none
package btc_pkg;

    localparam int TIME_W     = 32;
    localparam int DBT_W      = 20;
    localparam int POLLS_W    = 4;
    localparam int TAP_MIN_W  = 20;
    localparam int WINDOW_W   = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_POLLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MIN        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_WINDOW     = 2'd3;

    localparam logic [DBT_W-1:0]     DEBOUNCE_TIME_RST  = 20'd12000;
    localparam logic [POLLS_W-1:0]   DEBOUNCE_POLLS_RST = 4'd2;
    localparam logic [TAP_MIN_W-1:0] TAP_MIN_RST        = 20'd20000;
    localparam logic [WINDOW_W-1:0]  TAP_WINDOW_RST     = 24'd135000;

    typedef struct packed {
        logic              raw_pressed;
        logic [TIME_W-1:0] now_us;
        logic              tap_mode;
        logic              clear_tap;
    } btc_poll_t;

    typedef struct packed {
        logic pressed_debounced;
        logic fire_request;
        logic tap_event;
        logic held_off;
    } btc_result_t;

endpackage
`default_nettype wire

[src/btc_if.sv]
`default_nettype none
interface btc_poll_if import btc_pkg::*;;
    logic      valid;
    logic      ready;
    btc_poll_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface btc_result_if import btc_pkg::*;;
    logic        valid;
    logic        ready;
    btc_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface btc_cfg_if import btc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

[src/button_tap_hold_classifier.sv]
// An accepted poll is held in the poll register; its result word is then held in the result register.
// Throughput: one poll per cycle unless the result side stalls; the state update is a single
// pass of 32-bit subtracts and compares between the poll register and the result register.
// Reset (rst_n low, asynchronous): pipeline empty, button released, all timing
// state zero, configuration registers at their default values.
`default_nettype none
module button_tap_hold_classifier
    import btc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    btc_poll_if.sink      poll,
    btc_result_if.source  result,
    btc_cfg_if.sink       cfg
);

    // Configuration registers.
    logic [DBT_W-1:0]     debounce_time_us_reg;
    logic [POLLS_W-1:0]   debounce_polls_reg;
    logic [TAP_MIN_W-1:0] tap_min_us_reg;
    logic [WINDOW_W-1:0]  tap_window_us_reg;

    // Button state.
    logic               stable_level_reg, stable_level_next;
    logic               last_raw_reg, last_raw_next;
    logic [POLLS_W-1:0] poll_count_reg, poll_count_next;
    logic [TIME_W-1:0]  edge_time_reg, edge_time_next;
    logic [TIME_W-1:0]  press_time_reg, press_time_next;
    logic               expired_reg, expired_next;
    logic               tap_pending_reg, tap_pending_next;
    logic               hold_gate_next;

    // Pipeline.
    logic        poll_valid_reg;
    btc_poll_t   poll_data_reg;
    logic        result_valid_reg;
    btc_result_t result_data_reg, result_data_next;
    logic        advance;

    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_edge;
    logic [TIME_W-1:0] press_width;
    logic              level_ok;

    assign cfg.ready    = 1'b1;
    assign advance      = poll_valid_reg && (!result_valid_reg || result.ready);
    assign poll.ready   = !poll_valid_reg || advance;
    assign result.valid = result_valid_reg;
    assign result.data  = result_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_us_reg <= DEBOUNCE_TIME_RST;
            debounce_polls_reg   <= DEBOUNCE_POLLS_RST;
            tap_min_us_reg       <= TAP_MIN_RST;
            tap_window_us_reg    <= TAP_WINDOW_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DEBOUNCE_TIME:  debounce_time_us_reg <= cfg.wdata[DBT_W-1:0];
                REG_DEBOUNCE_POLLS: debounce_polls_reg   <= cfg.wdata[POLLS_W-1:0];
                REG_TAP_MIN:        tap_min_us_reg       <= cfg.wdata[TAP_MIN_W-1:0];
                REG_TAP_WINDOW:     tap_window_us_reg    <= cfg.wdata[WINDOW_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        btc_poll_t p;
        p = poll_data_reg;

        tap_pending_next = tap_pending_reg && !p.clear_tap;

        last_raw_next   = p.raw_pressed;
        poll_count_next = poll_count_reg;
        edge_time_next  = edge_time_reg;
        if (p.raw_pressed != last_raw_reg)
        begin
            poll_count_next = '0;
            edge_time_next  = p.now_us;
        end
        else if (poll_count_reg < debounce_polls_reg)
        begin
            poll_count_next = POLLS_W'(poll_count_reg + 1'b1);
        end

        // The expiry test looks at the level and press time from before this poll.
        since_press  = p.now_us - press_time_reg;
        expired_next = expired_reg;
        if (stable_level_reg && p.raw_pressed &&
            since_press > {{(TIME_W-WINDOW_W){1'b0}}, tap_window_us_reg})
        begin
            expired_next = 1'b1;
        end

        since_edge  = p.now_us - edge_time_next;
        press_width = edge_time_next - press_time_reg;
        level_ok    = (poll_count_next >= debounce_polls_reg) &&
                      (since_edge >= {{(TIME_W-DBT_W){1'b0}}, debounce_time_us_reg});

        stable_level_next = stable_level_reg;
        press_time_next   = press_time_reg;
        if (level_ok && (stable_level_reg != p.raw_pressed))
        begin
            stable_level_next = p.raw_pressed;
            if (p.raw_pressed)
            begin
                press_time_next  = edge_time_next;
                expired_next     = 1'b0;
                tap_pending_next = 1'b0;
            end
            else
            begin
                if (p.tap_mode && !expired_next &&
                    press_width >= {{(TIME_W-TAP_MIN_W){1'b0}}, tap_min_us_reg})
                begin
                    tap_pending_next = 1'b1;
                end
                expired_next = 1'b0;
            end
        end

        hold_gate_next = p.tap_mode && stable_level_next && !expired_next;

        result_data_next.pressed_debounced = stable_level_next;
        result_data_next.fire_request      = stable_level_next && !hold_gate_next;
        result_data_next.tap_event         = tap_pending_next;
        result_data_next.held_off          = hold_gate_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_level_reg <= 1'b0;
            last_raw_reg     <= 1'b0;
            poll_count_reg   <= '0;
            edge_time_reg    <= '0;
            press_time_reg   <= '0;
            expired_reg      <= 1'b0;
            tap_pending_reg  <= 1'b0;
            poll_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll.valid && poll.ready)
            begin
                poll_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                poll_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                stable_level_reg <= stable_level_next;
                last_raw_reg     <= last_raw_next;
                poll_count_reg   <= poll_count_next;
                edge_time_reg    <= edge_time_next;
                press_time_reg   <= press_time_next;
                expired_reg      <= expired_next;
                tap_pending_reg  <= tap_pending_next;
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            poll_data_reg <= poll.data;
        end
        if (advance)
        begin
            result_data_reg <= result_data_next;
        end
    end

endmodule
`default_nettype wire

[src/btc_checker.sv]
`default_nettype none
module btc_checker
    import btc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        poll_valid,
    input wire logic        poll_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire btc_result_t result_data
);

    // A fire request always comes from a debounced press.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result_data.fire_request || result_data.pressed_debounced))
    else $error("fire request without a debounced press");

    // Holding off and firing are exclusive, and one of them covers every press.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.fire_request ==
                          (result_data.pressed_debounced && !result_data.held_off)))
    else $error("fire request and hold-off disagree");

    // With the result side ready once the poll is registered, an accepted poll yields a valid result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (poll_valid && poll_ready) ##1 result_ready |=> result_valid)
    else $error("accepted poll produced no result word");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_data)))
    else $error("stalled result word changed");

endmodule

bind button_tap_hold_classifier btc_checker u_btc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .poll_valid   (poll.valid),
    .poll_ready   (poll.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
`default_nettype wire

[dv/tb_button_tap_hold_classifier.sv]
`timescale 1ns / 1ps
module tb_button_tap_hold_classifier;
    import btc_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TIMEOUT_CYCLES = 200000;

    logic clk;
    logic rst_n;

    btc_poll_if   poll_bus ();
    btc_result_if result_bus ();
    btc_cfg_if    cfg_bus ();

    button_tap_hold_classifier DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Local copy of the configuration registers.
    logic [DBT_W-1:0]     cfg_debounce_us;
    logic [POLLS_W-1:0]   cfg_polls;
    logic [TAP_MIN_W-1:0] cfg_tap_min_us;
    logic [WINDOW_W-1:0]  cfg_window_us;

    // Local copy of the classifier state.
    logic               btn_level;
    logic               raw_seen;
    logic [POLLS_W-1:0] hold_polls;
    logic [TIME_W-1:0]  raw_edge_us;
    logic [TIME_W-1:0]  press_edge_us;
    logic               window_done;
    logic               tap_flag;
    logic               gate_held;

    btc_result_t       expected_button_states[$];
    int                error_count;
    int                polls_sent;
    logic              steady_flow;
    logic [TIME_W-1:0] clock_us;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic btc_result_t classify_poll(input btc_poll_t p);
        logic [TIME_W-1:0] since_press;
        logic [TIME_W-1:0] since_edge;
        logic [TIME_W-1:0] press_width;
        btc_result_t       r;
        if (p.clear_tap)
            tap_flag = 1'b0;
        if (p.raw_pressed != raw_seen)
        begin
            raw_seen    = p.raw_pressed;
            hold_polls  = '0;
            raw_edge_us = p.now_us;
        end
        else if (hold_polls < cfg_polls)
            hold_polls = hold_polls + 1'b1;
        // The window test looks at the accepted level from before this poll.
        since_press = p.now_us - press_edge_us;
        if (btn_level && p.raw_pressed && since_press > TIME_W'(cfg_window_us))
            window_done = 1'b1;
        since_edge = p.now_us - raw_edge_us;
        if (hold_polls >= cfg_polls && since_edge >= TIME_W'(cfg_debounce_us)
            && btn_level != p.raw_pressed)
        begin
            btn_level = p.raw_pressed;
            if (p.raw_pressed)
            begin
                press_edge_us = raw_edge_us;
                window_done   = 1'b0;
                tap_flag      = 1'b0;
            end
            else
            begin
                press_width = raw_edge_us - press_edge_us;
                if (p.tap_mode && !window_done && press_width >= TIME_W'(cfg_tap_min_us))
                    tap_flag = 1'b1;
                window_done = 1'b0;
            end
        end
        gate_held = p.tap_mode && btn_level && !window_done;
        r.pressed_debounced = btn_level;
        r.fire_request      = btn_level && !gate_held;
        r.tap_event         = tap_flag;
        r.held_off          = gate_held;
        return r;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            error_count++;
        end
    endtask

    // Result side: every accepted word is compared with the oldest prediction.
    initial
    begin
        btc_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                if (expected_button_states.size() == 0)
                begin
                    $error("result word arrived with no poll waiting for it");
                    error_count++;
                end
                else
                begin
                    want = expected_button_states.pop_front();
                    check_field("pressed_debounced", want.pressed_debounced,
                                result_bus.data.pressed_debounced);
                    check_field("fire_request", want.fire_request,
                                result_bus.data.fire_request);
                    check_field("tap_event", want.tap_event, result_bus.data.tap_event);
                    check_field("held_off", want.held_off, result_bus.data.held_off);
                end
            end
        end
    end

    // Result side backpressure in short random bursts.
    initial
    begin
        result_bus.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!steady_flow && $urandom_range(0, 4) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_poll(input logic raw, input logic [TIME_W-1:0] now,
                             input logic mode, input logic clr);
        btc_poll_t p;
        p.raw_pressed = raw;
        p.now_us      = now;
        p.tap_mode    = mode;
        p.clear_tap   = clr;
        if (!steady_flow && $urandom_range(0, 5) == 0)
        begin
            poll_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        poll_bus.valid <= 1'b1;
        poll_bus.data  <= p;
        @(posedge clk);
        while (!poll_bus.ready)
            @(posedge clk);
        expected_button_states.push_back(classify_poll(p));
        polls_sent++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.wdata <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            REG_DEBOUNCE_TIME:  cfg_debounce_us = value[DBT_W-1:0];
            REG_DEBOUNCE_POLLS: cfg_polls       = value[POLLS_W-1:0];
            REG_TAP_MIN:        cfg_tap_min_us  = value[TAP_MIN_W-1:0];
            REG_TAP_WINDOW:     cfg_window_us   = value[WINDOW_W-1:0];
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops the poll stream and lets every outstanding word come back.
    task automatic drain_results();
        int waited;
        poll_bus.valid <= 1'b0;
        waited = 0;
        while (expected_button_states.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_button_states.size() != 0)
        begin
            $error("%0d result words never arrived", expected_button_states.size());
            error_count++;
            expected_button_states.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic send_run(input logic level, input int count, input int unsigned step_max,
                            inout logic mode);
        for (int i = 0; i < count; i++)
        begin
            clock_us += $urandom_range(0, step_max);
            if ($urandom_range(0, 9) == 0)
                mode = ~mode;
            send_poll(level, clock_us, mode, $urandom_range(0, 9) == 0);
        end
    endtask

    // Taps, a release past the 32-bit wrap, a hold that expires on the exact
    // boundary plus one, and switching tap mode while the button is down.
    task automatic test_tap_window_wrap();
        drain_results();
        write_register(REG_DEBOUNCE_TIME, 24'd10);
        write_register(REG_DEBOUNCE_POLLS, 24'd1);
        write_register(REG_TAP_MIN, 24'd20);
        write_register(REG_TAP_WINDOW, 24'd100);
        send_poll(1'b0, 32'hFFFF_FFF0, 1'b1, 1'b0);
        send_poll(1'b1, 32'hFFFF_FFF8, 1'b1, 1'b0);
        send_poll(1'b1, 32'h0000_0002, 1'b1, 1'b0);
        send_poll(1'b0, 32'h0000_0010, 1'b1, 1'b0);
        send_poll(1'b1, 32'h0000_0012, 1'b1, 1'b0);
        // Wider than the window, but the expiry only latches while raw is down.
        send_poll(1'b0, 32'h0000_0060, 1'b1, 1'b0);
        send_poll(1'b0, 32'h0000_0070, 1'b1, 1'b0);
        send_poll(1'b1, 32'h0000_0100, 1'b1, 1'b1);
        send_poll(1'b1, 32'h0000_0110, 1'b1, 1'b0);
        send_poll(1'b1, 32'h0000_0164, 1'b1, 1'b0);
        send_poll(1'b1, 32'h0000_0165, 1'b1, 1'b0);
        send_poll(1'b0, 32'h0000_0170, 1'b1, 1'b0);
        send_poll(1'b0, 32'h0000_0180, 1'b1, 1'b0);
        send_poll(1'b1, 32'h0000_0200, 1'b0, 1'b0);
        send_poll(1'b1, 32'h0000_0210, 1'b0, 1'b0);
        send_poll(1'b1, 32'h0000_0220, 1'b1, 1'b0);
        send_poll(1'b1, 32'h0000_0221, 1'b0, 1'b0);
        send_poll(1'b0, 32'h0000_0230, 1'b1, 1'b0);
        send_poll(1'b0, 32'h0000_0240, 1'b1, 1'b0);
        send_poll(1'b1, 32'h0000_0250, 1'b1, 1'b0);
        send_poll(1'b1, 32'h0000_0260, 1'b1, 1'b0);
        send_poll(1'b0, 32'h0000_0265, 1'b1, 1'b0);
        send_poll(1'b0, 32'h0000_0275, 1'b1, 1'b1);
    endtask

    // Zero thresholds with masked upper bits, then a poll threshold lowered
    // below a count that has already run past it.
    task automatic test_debounce_thresholds();
        logic mode;
        drain_results();
        write_register(REG_DEBOUNCE_TIME, 24'hF0_0000);
        write_register(REG_DEBOUNCE_POLLS, 24'hFF_FFF0);
        send_poll(1'b1, 32'h0000_1000, 1'b1, 1'b0);
        send_poll(1'b0, 32'h0000_1001, 1'b0, 1'b0);
        drain_results();
        write_register(REG_DEBOUNCE_TIME, 24'd1000000);
        write_register(REG_DEBOUNCE_POLLS, 24'd4);
        clock_us = 32'h0000_1FFF;
        mode     = 1'b0;
        send_run(1'b1, 5, 1, mode);
        drain_results();
        write_register(REG_DEBOUNCE_TIME, 24'd5);
        write_register(REG_DEBOUNCE_POLLS, 24'd2);
        send_poll(1'b1, 32'h0000_2010, 1'b0, 1'b0);
    endtask

    // Mostly well-formed press and release sequences with contact bounce at
    // both edges, mixed with polls of random noise.
    task automatic test_random_phase(input int n_polls, input logic [CFG_DATA_W-1:0] dbt,
                                     input logic [CFG_DATA_W-1:0] polls,
                                     input logic [CFG_DATA_W-1:0] tmin,
                                     input logic [CFG_DATA_W-1:0] win);
        int unsigned step_max;
        int          stop;
        int          bounce;
        logic        mode;
        logic        level;
        drain_results();
        write_register(REG_DEBOUNCE_TIME, dbt);
        write_register(REG_DEBOUNCE_POLLS, polls);
        write_register(REG_TAP_MIN, tmin);
        write_register(REG_TAP_WINDOW, win);
        step_max = cfg_window_us / 4 + cfg_debounce_us / 2 + 2;
        stop     = polls_sent + n_polls;
        clock_us = $urandom;
        while (polls_sent < stop)
        begin
            if ($urandom_range(0, 6) == 0)
                send_poll(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            else
            begin
                mode = ($urandom_range(0, 3) != 0);
                for (int half = 0; half < 2; half++)
                begin
                    level  = (half == 0);
                    bounce = $urandom_range(0, 3);
                    for (int i = 0; i < bounce; i++)
                    begin
                        clock_us += $urandom_range(0, step_max / 8);
                        send_poll((i % 2 == 0) ? level : !level, clock_us, mode, 1'b0);
                    end
                    send_run(level, $urandom_range(1, 2 * cfg_polls + 6), step_max, mode);
                end
            end
        end
    endtask

    initial
    begin
        poll_bus.valid  <= 1'b0;
        poll_bus.data   <= '0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.index   <= '0;
        cfg_bus.wdata   <= '0;
        rst_n           <= 1'b0;
        steady_flow     = 1'b0;
        error_count     = 0;
        polls_sent      = 0;
        clock_us        = '0;
        cfg_debounce_us = DEBOUNCE_TIME_RST;
        cfg_polls       = DEBOUNCE_POLLS_RST;
        cfg_tap_min_us  = TAP_MIN_RST;
        cfg_window_us   = TAP_WINDOW_RST;
        btn_level       = 1'b0;
        raw_seen        = 1'b0;
        hold_polls      = '0;
        raw_edge_us     = '0;
        press_edge_us   = '0;
        window_done     = 1'b0;
        tap_flag        = 1'b0;
        gate_held       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tap_window_wrap();
        test_debounce_thresholds();
        test_random_phase(170, DEBOUNCE_TIME_RST, DEBOUNCE_POLLS_RST, TAP_MIN_RST,
                          TAP_WINDOW_RST);
        test_random_phase(170, CFG_DATA_W'($urandom_range(0, 60)),
                          CFG_DATA_W'($urandom_range(0, 5)),
                          CFG_DATA_W'($urandom_range(0, 150)),
                          CFG_DATA_W'($urandom_range(0, 400)));
        test_random_phase(170, 24'd1000000, 24'd15, 24'd1000000, 24'd10000000);
        test_random_phase(170, 24'd0, 24'd0, 24'd0, 24'd0);
        test_random_phase(170, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        steady_flow = 1'b1;
        test_random_phase(170, CFG_DATA_W'($urandom_range(0, 60)),
                          CFG_DATA_W'($urandom_range(0, 5)),
                          CFG_DATA_W'($urandom_range(0, 150)),
                          CFG_DATA_W'($urandom_range(0, 400)));
        drain_results();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
